FILE: rtl/wrms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrms_pkg
// Shared types, mode codes, register indexes and wheel commands for the
// wandering robot motion sequencer.
// ----------------------------------------------------------------------------
package wrms_pkg;

  localparam int TIME_BITS  = 32;
  localparam int REG_BITS   = 24;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_BITS  = FRAC_BITS + REG_BITS;
  localparam int SPEED_BITS = 5;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [TIME_BITS-1:0]         tick_t;
  typedef logic [REG_BITS-1:0]          span_t;
  typedef logic [FRAC_BITS-1:0]         frac_t;
  typedef logic signed [SPEED_BITS-1:0] speed_t;
  typedef logic [CFG_IDX_BITS-1:0]      cfg_index_t;

  typedef enum logic [1:0] {
    MODE_FORWARD = 2'd0,
    MODE_LONG    = 2'd1,
    MODE_NOISE   = 2'd2,
    MODE_SHORT   = 2'd3
  } mode_t;

  localparam cfg_index_t CFG_PERIOD_LONG   = 3'd0;
  localparam cfg_index_t CFG_PERIOD_NOISE  = 3'd1;
  localparam cfg_index_t CFG_DURATION_LONG = 3'd2;
  localparam cfg_index_t CFG_DURATION_SHORT = 3'd3;
  localparam cfg_index_t CFG_NOISE_MAX     = 3'd4;

  localparam span_t RST_PERIOD_LONG    = 24'd20000;
  localparam span_t RST_PERIOD_NOISE   = 24'd5000;
  localparam span_t RST_DURATION_LONG  = 24'd2150;
  localparam span_t RST_DURATION_SHORT = 24'd537;
  localparam span_t RST_NOISE_MAX      = 24'd1911;

  // wheel commands in eighths of full speed
  localparam speed_t SPEED_FULL     = 5'sd8;
  localparam speed_t SPEED_SPIN_FWD = 5'sd4;
  localparam speed_t SPEED_SPIN_REV = -5'sd4;
  localparam speed_t SPEED_VEER_OUT = 5'sd4;
  localparam speed_t SPEED_VEER_IN  = 5'sd3;

  typedef struct packed {
    span_t period_long;
    span_t period_noise;
    span_t duration_long;
    span_t duration_short;
    span_t noise_max;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    tick_t long_start;
    tick_t short_start;
    tick_t noise_start;
    span_t noise_length;
    logic  veer_right;
  } motion_state_t;

  // wrap-safe elapsed time test: strictly past the span
  function automatic logic is_due(tick_t now, tick_t start, span_t span);
    tick_t diff;
    diff = now - start;
    return diff > tick_t'(span);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/wrms_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrms_step
// Next-state and wheel command logic for one tick of the motion sequencer.
// ----------------------------------------------------------------------------
module wrms_step
  import wrms_pkg::*;
(
  input  tick_t         now,
  input  motion_state_t state,
  input  cfg_t          cfg,
  input  logic          front_bump,
  input  logic          top_bump,
  input  frac_t         random_fraction,
  input  logic          random_side,
  output motion_state_t state_next,
  output speed_t        left_speed,
  output speed_t        right_speed
);

  logic [PROD_BITS-1:0] product;
  span_t                noise_len_new;

  assign product       = PROD_BITS'(random_fraction) * PROD_BITS'(cfg.noise_max);
  assign noise_len_new = product[PROD_BITS-1:FRAC_BITS];

  always_comb begin
    state_next  = state;
    left_speed  = SPEED_FULL;
    right_speed = SPEED_FULL;

    // forward: later checks override earlier ones
    if (state_next.mode == MODE_FORWARD) begin
      left_speed  = SPEED_FULL;
      right_speed = SPEED_FULL;
      if (is_due(now, state.long_start, cfg.period_long)) begin
        state_next.long_start = now;
        state_next.mode       = MODE_LONG;
      end
      if (is_due(now, state.noise_start, cfg.period_noise)) begin
        state_next.noise_start  = now;
        state_next.noise_length = noise_len_new;
        state_next.veer_right   = random_side;
        state_next.mode         = MODE_NOISE;
      end
      if (front_bump) begin
        state_next.long_start = now;
        state_next.mode       = MODE_LONG;
      end
      if (top_bump) begin
        state_next.short_start = now;
        state_next.mode        = MODE_SHORT;
      end
    end

    if (state_next.mode == MODE_LONG) begin
      left_speed  = SPEED_SPIN_FWD;
      right_speed = SPEED_SPIN_REV;
      if (is_due(now, state_next.long_start, cfg.duration_long)) begin
        state_next.mode = MODE_FORWARD;
      end
    end

    if (state_next.mode == MODE_SHORT) begin
      left_speed  = SPEED_SPIN_FWD;
      right_speed = SPEED_SPIN_REV;
      if (is_due(now, state_next.short_start, cfg.duration_short)) begin
        state_next.mode = MODE_FORWARD;
      end
    end

    // a front bump here changes the mode and restarts the long spin time, the veer wheels stay
    if (state_next.mode == MODE_NOISE) begin
      if (state_next.veer_right) begin
        left_speed  = SPEED_VEER_OUT;
        right_speed = SPEED_VEER_IN;
      end else begin
        left_speed  = SPEED_VEER_IN;
        right_speed = SPEED_VEER_OUT;
      end
      if (is_due(now, state_next.noise_start, state_next.noise_length)) begin
        state_next.mode = MODE_FORWARD;
      end
      if (front_bump) begin
        state_next.long_start = now;
        state_next.mode       = MODE_LONG;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wandering_robot_motion_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// a result is in the output register the cycle after its tick is accepted
// throughput: one tick per cycle while the output drains, set by the single output register stage
// the input side stalls only while a finished result waits on the output side
// reset (rst, synchronous, active high) restores the register defaults, clears
// the tick counter and all turn start times and returns the mode to forward
// ----------------------------------------------------------------------------
// wandering_robot_motion_sequencer
// Per-tick motion mode sequencer for a wandering ground robot: periodic long
// spins, random noise veers and bump-triggered spins, with wheel commands.
// ----------------------------------------------------------------------------
module wandering_robot_motion_sequencer
  import wrms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_index_t  cfg_index,
  input  span_t       cfg_data,
  // tick input: front_bump[0], top_bump[1], random_fraction[17:2],
  // random_side[18], zero fill [23:19]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  // result: motion_mode[1:0], left_speed[6:2], right_speed[11:7],
  // zero fill [15:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata
);

  cfg_t          cfg;
  tick_t         tick_now;
  motion_state_t state;
  motion_state_t state_next;
  speed_t        left_next;
  speed_t        right_next;
  mode_t         out_mode;
  speed_t        out_left;
  speed_t        out_right;
  logic          in_xfer;

  // input field unpacking
  logic  front_bump;
  logic  top_bump;
  frac_t random_fraction;
  logic  random_side;

  assign front_bump      = s_axis_tdata[0];
  assign top_bump        = s_axis_tdata[1];
  assign random_fraction = s_axis_tdata[17:2];
  assign random_side     = s_axis_tdata[18];

  // registers are always writable; writes must arrive only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_long    <= RST_PERIOD_LONG;
      cfg.period_noise   <= RST_PERIOD_NOISE;
      cfg.duration_long  <= RST_DURATION_LONG;
      cfg.duration_short <= RST_DURATION_SHORT;
      cfg.noise_max      <= RST_NOISE_MAX;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PERIOD_LONG:    cfg.period_long    <= cfg_data;
        CFG_PERIOD_NOISE:   cfg.period_noise   <= cfg_data;
        CFG_DURATION_LONG:  cfg.duration_long  <= cfg_data;
        CFG_DURATION_SHORT: cfg.duration_short <= cfg_data;
        CFG_NOISE_MAX:      cfg.noise_max      <= cfg_data;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // output register frees up when it is empty or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  wrms_step u_step (
    .now             (tick_now),
    .state           (state),
    .cfg             (cfg),
    .front_bump      (front_bump),
    .top_bump        (top_bump),
    .random_fraction (random_fraction),
    .random_side     (random_side),
    .state_next      (state_next),
    .left_speed      (left_next),
    .right_speed     (right_next)
  );

  // motion state and tick counter advance once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now           <= '0;
      state.mode         <= MODE_FORWARD;
      state.long_start   <= '0;
      state.short_start  <= '0;
      state.noise_start  <= '0;
      state.noise_length <= '0;
      state.veer_right   <= 1'b0;
    end else if (in_xfer) begin
      tick_now <= tick_now + tick_t'(1);
      state    <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_mode  <= state_next.mode;
      out_left  <= left_next;
      out_right <= right_next;
    end
  end

  assign m_axis_tdata = {4'b0000, out_right, out_left, out_mode};

endmodule
`default_nettype wire

FILE: rtl/wrms_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wrms_checker
// Port-level checks on the motion sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module wrms_checker
  import wrms_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire cfg_index_t  cfg_index,
  input wire span_t       cfg_data,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [23:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // every accepted tick produces a result the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted tick gave no result");

  // input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a pending result");

  // a short spin result always carries spin wheel commands
  a_short_wheels: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] == MODE_SHORT) |->
      (m_axis_tdata[6:2] == SPEED_SPIN_FWD) && (m_axis_tdata[11:7] == SPEED_SPIN_REV))
    else $error("short spin with wrong wheel commands");

  // full left speed only ever comes with full right speed and zero fill bits
  a_forward_wheels: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[6:2] == SPEED_FULL) |->
      (m_axis_tdata[11:7] == SPEED_FULL) && (m_axis_tdata[15:12] == 4'b0000))
    else $error("forward wheel commands inconsistent");

endmodule

bind wandering_robot_motion_sequencer wrms_checker u_wrms_checker (.*);
`default_nettype wire

FILE: tb/sv/motion_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_checker
// Watches the register, tick and result channels of the motion sequencer,
// tracks its mode and turn timers, and compares each result with the
// expected wheel commands.
// ----------------------------------------------------------------------------
module motion_checker
  import wrms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  cfg_index_t  cfg_index,
  input  span_t       cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int          pending,
  output int          failures
);

  typedef struct packed {
    logic  side;
    frac_t frac;
    logic  top_bump;
    logic  front_bump;
  } tick_in_t;

  typedef struct packed {
    mode_t  mode;
    speed_t left;
    speed_t right;
  } wheel_cmd_t;

  cfg_t          regs;
  motion_state_t motion;
  tick_t         tick_count;
  wheel_cmd_t    expected_cmds[$];

  initial begin
    pending  = 0;
    failures = 0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    failures++;
  endtask

  // strictly past the span, modulo the tick counter width
  function automatic bit span_elapsed(tick_t now, tick_t start, span_t span);
    tick_t gone;
    gone = now - start;
    return gone > tick_t'(span);
  endfunction

  function automatic wheel_cmd_t advance_motion(tick_in_t t);
    wheel_cmd_t             cmd;
    tick_t                  now;
    logic [PROD_BITS-1:0]   prod;
    now       = tick_count;
    cmd.left  = '0;
    cmd.right = '0;
    if (motion.mode == MODE_FORWARD) begin
      cmd.left  = SPEED_FULL;
      cmd.right = SPEED_FULL;
      if (span_elapsed(now, motion.long_start, regs.period_long)) begin
        motion.long_start = now;
        motion.mode       = MODE_LONG;
      end
      if (span_elapsed(now, motion.noise_start, regs.period_noise)) begin
        motion.noise_start  = now;
        prod                = PROD_BITS'(t.frac) * PROD_BITS'(regs.noise_max);
        motion.noise_length = prod[PROD_BITS-1:FRAC_BITS];
        motion.veer_right   = t.side;
        motion.mode         = MODE_NOISE;
      end
      if (t.front_bump) begin
        motion.long_start = now;
        motion.mode       = MODE_LONG;
      end
      if (t.top_bump) begin
        motion.short_start = now;
        motion.mode        = MODE_SHORT;
      end
    end
    if (motion.mode == MODE_LONG) begin
      cmd.left  = SPEED_SPIN_FWD;
      cmd.right = SPEED_SPIN_REV;
      if (span_elapsed(now, motion.long_start, regs.duration_long))
        motion.mode = MODE_FORWARD;
    end
    if (motion.mode == MODE_SHORT) begin
      cmd.left  = SPEED_SPIN_FWD;
      cmd.right = SPEED_SPIN_REV;
      if (span_elapsed(now, motion.short_start, regs.duration_short))
        motion.mode = MODE_FORWARD;
    end
    if (motion.mode == MODE_NOISE) begin
      if (motion.veer_right) begin
        cmd.left  = SPEED_VEER_OUT;
        cmd.right = SPEED_VEER_IN;
      end else begin
        cmd.left  = SPEED_VEER_IN;
        cmd.right = SPEED_VEER_OUT;
      end
      if (span_elapsed(now, motion.noise_start, motion.noise_length))
        motion.mode = MODE_FORWARD;
      // a front bump cuts the veer short but keeps this tick's veer commands
      if (t.front_bump) begin
        motion.long_start = now;
        motion.mode       = MODE_LONG;
      end
    end
    tick_count = now + 1'b1;
    cmd.mode   = motion.mode;
    return cmd;
  endfunction

  always @(posedge clk) begin : watch
    wheel_cmd_t want;
    logic [1:0] got_mode;
    speed_t     got_left;
    speed_t     got_right;
    if (rst) begin
      regs       = '{RST_PERIOD_LONG, RST_PERIOD_NOISE, RST_DURATION_LONG,
                     RST_DURATION_SHORT, RST_NOISE_MAX};
      motion     = '0;
      tick_count = '0;
      expected_cmds.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PERIOD_LONG:    regs.period_long    = cfg_data;
          CFG_PERIOD_NOISE:   regs.period_noise   = cfg_data;
          CFG_DURATION_LONG:  regs.duration_long  = cfg_data;
          CFG_DURATION_SHORT: regs.duration_short = cfg_data;
          CFG_NOISE_MAX:      regs.noise_max      = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_cmds.push_back(advance_motion(tick_in_t'(s_axis_tdata[18:0])));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", m_axis_tdata));
        end else begin
          want      = expected_cmds.pop_front();
          got_mode  = m_axis_tdata[1:0];
          got_left  = m_axis_tdata[6:2];
          got_right = m_axis_tdata[11:7];
          if (got_mode !== want.mode)
            report_mismatch($sformatf("motion_mode got %0d want %0d",
                                      got_mode, want.mode));
          if (got_left !== want.left)
            report_mismatch($sformatf("left_speed got %0d want %0d",
                                      got_left, want.left));
          if (got_right !== want.right)
            report_mismatch($sformatf("right_speed got %0d want %0d",
                                      got_right, want.right));
          if (m_axis_tdata[15:12] !== 4'b0)
            report_mismatch($sformatf("fill bits got %b", m_axis_tdata[15:12]));
        end
      end
    end
    pending <= expected_cmds.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives ticks and register writes into the motion sequencer with random
// gaps and back-pressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top
  import wrms_pkg::*;
();

  // run limit, several times the slowest legal run
  localparam int TIMEOUT_NS   = 16_000_000;
  // receiver hold-off long enough to back the block up into the sender
  localparam int HOLD_CYCLES  = 300;
  localparam span_t SPAN_MAX  = '1;
  // indexes with no register behind them
  localparam cfg_index_t CFG_UNMAPPED_LO = CFG_NOISE_MAX + 1'b1;
  localparam cfg_index_t CFG_UNMAPPED_HI = '1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = '0;
  span_t       cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // front_bump[0], top_bump[1], random_fraction[17:2], random_side[18], zero fill
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // motion_mode[1:0], left_speed[6:2], right_speed[11:7], zero fill
  logic [15:0] m_axis_tdata;

  int pending;
  int failures;

  // shared between the stimulus and the receiver process
  bit hold_req = 1'b0;
  bit no_idle  = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  wandering_robot_motion_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  motion_checker u_motion_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending       (pending),
    .failures      (failures)
  );

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one tick transaction; valid stays high into the next tick when there is no gap
  task automatic offer_tick(bit front, bit top_hit, frac_t frac, bit side);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, side, frac, top_hit, front};
    do @(posedge clk); while (!s_axis_tready);
    gap = hold_req ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic idle_until_drained();
    s_axis_tvalid <= 1'b0;
    // the first edge lets the checker count a tick accepted just now
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  // register writes go back to back; valid drops only after the last one
  task automatic write_reg(cfg_index_t idx, span_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(cfg_t c, bit poke_unmapped);
    idle_until_drained();
    write_reg(CFG_PERIOD_LONG,    c.period_long);
    write_reg(CFG_PERIOD_NOISE,   c.period_noise);
    write_reg(CFG_DURATION_LONG,  c.duration_long);
    write_reg(CFG_DURATION_SHORT, c.duration_short);
    write_reg(CFG_NOISE_MAX,      c.noise_max);
    // writes to unmapped indexes must leave every register alone
    if (poke_unmapped) begin
      write_reg(CFG_UNMAPPED_LO, span_t'($urandom));
      write_reg(CFG_UNMAPPED_HI, SPAN_MAX);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random ticks; bumps kept rare so timers get a chance to run out
  task automatic run_random(int count, int bump_pct);
    frac_t frac;
    int    r;
    repeat (count) begin
      r = $urandom_range(0, 9);
      if (r == 0) frac = '0;
      else if (r == 1) frac = '1;
      else frac = frac_t'($urandom_range(0, 65535));
      offer_tick($urandom_range(0, 99) < bump_pct, $urandom_range(0, 99) < bump_pct,
                 frac, 1'($urandom_range(0, 1)));
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : drain
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin : stimulus
    cfg_t c;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults straight out of reset
    run_random(100, 8);

    // extremes: longest long-turn period, shortest noise period, zero-length
    // spins and the longest noise veer; walks through veer ends, front bump
    // during a veer, spins that end the tick after they start
    program_regs('{SPAN_MAX, 24'd1, 24'd0, 24'd0, SPAN_MAX}, 1'b1);
    offer_tick(1'b0, 1'b0, 16'h0000, 1'b0);
    offer_tick(1'b0, 1'b0, 16'hffff, 1'b1);
    offer_tick(1'b0, 1'b0, 16'hffff, 1'b1);
    offer_tick(1'b0, 1'b0, 16'h0000, 1'b0);
    offer_tick(1'b1, 1'b0, 16'h0000, 1'b0);
    offer_tick(1'b0, 1'b0, 16'h0000, 1'b0);
    offer_tick(1'b0, 1'b1, 16'h5555, 1'b0);
    offer_tick(1'b0, 1'b0, 16'haaaa, 1'b1);
    offer_tick(1'b1, 1'b1, 16'hffff, 1'b1);
    offer_tick(1'b0, 1'b0, 16'h0000, 1'b0);
    offer_tick(1'b0, 1'b0, 16'h8000, 1'b0);
    offer_tick(1'b0, 1'b1, 16'h0001, 1'b1);
    offer_tick(1'b1, 1'b0, 16'h7fff, 1'b0);
    offer_tick(1'b0, 1'b0, 16'h0000, 1'b1);
    offer_tick(1'b0, 1'b0, 16'hffff, 1'b0);
    offer_tick(1'b1, 1'b0, 16'h1234, 1'b1);
    offer_tick(1'b0, 1'b0, 16'h0000, 1'b0);
    offer_tick(1'b0, 1'b0, 16'h0000, 1'b0);
    offer_tick(1'b1, 1'b1, 16'h0000, 1'b0);
    offer_tick(1'b0, 1'b0, 16'hffff, 1'b1);
    run_random(80, 6);

    // short timers so every mode comes round often
    program_regs('{24'd40, 24'd15, 24'd6, 24'd3, 24'd20}, 1'b0);
    run_random(400, 5);

    // shortest periods and zero durations, no idling on either side
    no_idle = 1'b1;
    program_regs('{24'd1, 24'd1, 24'd0, 24'd0, 24'd0}, 1'b0);
    run_random(200, 10);
    no_idle = 1'b0;

    // longest spins: once a spin starts it outlasts the run
    program_regs('{24'd25, 24'd60, SPAN_MAX, SPAN_MAX, 24'd30}, 1'b1);
    run_random(150, 4);

    // back-pressure: receiver holds off while ticks keep coming, then the
    // sender pauses until everything has come back
    program_regs('{24'd100, 24'd30, 24'd10, 24'd5, 24'd50}, 1'b0);
    hold_req = 1'b1;
    run_random(250, 5);
    idle_until_drained();
    run_random(250, 5);

    // random small settings, with the noise maximum sometimes at its largest value
    repeat (3) begin
      c.period_long    = span_t'($urandom_range(1, 200));
      c.period_noise   = span_t'($urandom_range(1, 80));
      c.duration_long  = span_t'($urandom_range(0, 40));
      c.duration_short = span_t'($urandom_range(0, 20));
      c.noise_max      = ($urandom_range(0, 3) == 0) ? SPAN_MAX
                                                     : span_t'($urandom_range(0, 100));
      program_regs(c, 1'b0);
      run_random(160, $urandom_range(2, 20));
    end

    idle_until_drained();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: wandering_robot_motion_sequencer.f
rtl/wrms_pkg.sv
rtl/wrms_step.sv
rtl/wandering_robot_motion_sequencer.sv
rtl/wrms_checker.sv
tb/sv/motion_checker.sv
tb/sv/tb_top.sv
